/* hw/rtl/min_max_height_normalizer_macros.svh */
// ----------------------------------------------------------------------------
// Min/max height normalizer assertion macros
// Concurrent assertion shorthands, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_HEIGHT_NORMALIZER_MACROS_SVH
`define MIN_MAX_HEIGHT_NORMALIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define MMHN_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("mmhn assertion failed");

// Next-cycle implication.
`define MMHN_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("mmhn assertion failed");

`else

`define MMHN_ASSERT_IMPL(label, pre, post)
`define MMHN_ASSERT_NEXT(label, pre, post)

`endif

`endif

/* hw/rtl/mmhn_pkg.sv */
// ----------------------------------------------------------------------------
// Min/max height normalizer package
// Widths, operation codes, control structs and the result saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mmhn_pkg;

  // Base widths.
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int RANGE_W  = 16;

  // Derived widths: normalized value, result, and pre-saturation sum.
  localparam int NORM_W = FRAC_W + 1;
  localparam int RES_W  = FRAC_W + 2;
  localparam int SUM_W  = FRAC_W + 3;

  // Iteration counts of the shared unit.
  localparam int DIV_STEPS = FRAC_W;
  localparam int MUL_STEPS = NORM_W;
  localparam int CNT_W     = $clog2(MUL_STEPS + 1);

  // Request kinds.
  localparam logic [1:0] KIND_MEASURE   = 2'd0;
  localparam logic [1:0] KIND_NORMALIZE = 2'd1;
  localparam logic [1:0] KIND_RECOVER   = 2'd2;

  // Operations of the shared unit.
  typedef enum logic {
    OP_DIV,
    OP_MUL
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_cmd_t;

  typedef struct packed {
    logic done;
    logic big;
  } unit_stat_t;

  // Saturation bounds of a result.
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (SAMPLE_W - 1)));
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** FRAC_W);

  // Clamp a wide signed value into the result range.
  function automatic logic signed [RES_W-1:0] sat_result(logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] y;
    y = x;
    if (x < SAT_LO) begin
      y = SAT_LO;
    end else if (x > SAT_HI) begin
      y = SAT_HI;
    end
    return RES_W'(y);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mmhn_unit.sv */
// ----------------------------------------------------------------------------
// Shared add/subtract unit
// One adder serves restoring division (one quotient bit a cycle) and
// shift-add multiplication (one multiplier bit a cycle) under a step counter.
// ----------------------------------------------------------------------------
`default_nettype none

module mmhn_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mmhn_pkg::unit_cmd_t           cmd,
  input  wire logic [mmhn_pkg::NORM_W-1:0]   opa,
  input  wire logic [mmhn_pkg::RANGE_W-1:0]  opb,
  output mmhn_pkg::unit_stat_t               stat,
  output logic      [mmhn_pkg::FRAC_W-1:0]   quo,
  output logic      [mmhn_pkg::NORM_W-1:0]   prod
);
  import mmhn_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic                big_r, big_nxt;
  unit_op_t            op_r, op_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [NORM_W-1:0]   hi_r, hi_nxt;
  logic [NORM_W-1:0]   lo_r, lo_nxt;
  logic [NORM_W-1:0]   b_r, b_nxt;

  logic [NORM_W-1:0]   add_x;
  logic [NORM_W-1:0]   add_y;
  logic                add_sub;
  logic [NORM_W:0]     add_sum;
  logic [NORM_W-1:0]   div_x;

  // The shared adder; subtraction adds the inverted operand plus one.
  assign add_sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(NORM_W + 1){add_sub}})
                   + {{NORM_W{1'b0}}, add_sub};

  // Remainder shifted left for the next quotient bit.
  assign div_x = {hi_r[NORM_W-2:0], 1'b0};

  always_comb begin
    add_x   = div_x;
    add_y   = b_r;
    add_sub = 1'b1;
    if (op_r == OP_MUL) begin
      add_x   = hi_r;
      add_y   = lo_r[0] ? b_r : '0;
      add_sub = 1'b0;
    end
  end

  // Step sequencer.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    big_nxt  = big_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    b_nxt    = b_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      b_nxt    = NORM_W'(opb);
      big_nxt  = (opa >= NORM_W'(opb));
      if (cmd.op == OP_DIV) begin
        cnt_nxt = CNT_W'(DIV_STEPS);
        hi_nxt  = opa;
        lo_nxt  = '0;
      end else begin
        cnt_nxt = CNT_W'(MUL_STEPS);
        hi_nxt  = '0;
        lo_nxt  = opa;
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      if (op_r == OP_DIV) begin
        // Keep the difference when it did not go negative.
        if (!add_sum[NORM_W]) begin
          hi_nxt = add_sum[NORM_W-1:0];
          lo_nxt = {lo_r[NORM_W-2:0], 1'b1};
        end else begin
          hi_nxt = div_x;
          lo_nxt = {lo_r[NORM_W-2:0], 1'b0};
        end
      end else begin
        // Add the multiplicand on a set bit, then shift the pair right.
        hi_nxt = add_sum[NORM_W:1];
        lo_nxt = {add_sum[0], lo_r[NORM_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    big_r <= big_nxt;
    op_r  <= op_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    b_r   <= b_nxt;
  end

  // Quotient bits, and the product shifted down by the fraction width.
  assign stat.done = done_r;
  assign stat.big  = big_r;
  assign quo       = lo_r[FRAC_W-1:0];
  assign prod      = {hi_r[NORM_W-2:0], lo_r[NORM_W-1]};

endmodule

`default_nettype wire

/* hw/rtl/min_max_height_normalizer.sv */
// ----------------------------------------------------------------------------
// Min/max height normalizer
// Measures the height range of a pass, then normalizes or recovers heights.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall and are taken when in_valid is high
//   and in_stall low. Kind 0 requests are samples of a measure pass, ignored
//   while the normalized mark is set; the one marked last yields one result
//   carrying lowest_out, span_out, is_flat and stats_valid. Kind 1 maps a
//   height to Q1.16, kind 2 maps a Q1.16 value back to a height; each yields
//   one result. Results leave on out_valid/out_stall. cfg_min_range is
//   written on cfg_valid/cfg_ready. A measure sample that is not last is
//   taken in S_IDLE and yields nothing. A last sample passes through S_STATS
//   and S_EMIT into the output register, a pass-through or a flat mapping
//   through S_EMIT alone. A normalize runs 16 divider steps of the shared
//   adder in S_BUSY before S_EMIT; a recover runs 17 multiplier steps there.
//   The next request is taken once the result has entered the output
//   register, so the block takes no new request while one is in progress.
//   A result waiting on out_stall holds its payload; the block may take one
//   further request and hold its result until the output register frees.
//   Reset (rst_n low at a clock edge) clears the range, the span, the
//   normalized mark, min_range and any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_max_height_normalizer_macros.svh"

module min_max_height_normalizer (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic        [1:0]                    in_kind,
  input  wire logic signed [mmhn_pkg::SAMPLE_W-1:0] in_height_in,
  input  wire logic        [mmhn_pkg::NORM_W-1:0]   in_norm_in,
  input  wire logic                                 in_last,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed      [mmhn_pkg::RES_W-1:0]    out_result_value,
  output logic signed      [mmhn_pkg::SAMPLE_W-1:0] out_lowest_out,
  output logic             [mmhn_pkg::RANGE_W-1:0]  out_span_out,
  output logic                                      out_is_flat,
  output logic                                      out_stats_valid,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic        [mmhn_pkg::RANGE_W-1:0]  cfg_min_range
);
  import mmhn_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STATS,
    S_BUSY,
    S_EMIT
  } state_t;

  state_t                      state_r, state_nxt;
  logic signed [SAMPLE_W-1:0]  lowest_r, lowest_nxt;
  logic signed [SAMPLE_W-1:0]  highest_r, highest_nxt;
  logic        [RANGE_W-1:0]   span_r, span_nxt;
  logic                        flat_r, flat_nxt;
  logic                        norm_r, norm_nxt;
  logic                        started_r, started_nxt;
  logic        [RANGE_W-1:0]   min_range_r, min_range_nxt;
  logic signed [RES_W-1:0]     res_r, res_nxt;
  logic                        stat_r, stat_nxt;
  logic                        neg_r, neg_nxt;
  unit_op_t                    op_r, op_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic signed [RES_W-1:0]     out_res_r, out_res_nxt;
  logic signed [SAMPLE_W-1:0]  out_low_r, out_low_nxt;
  logic        [RANGE_W-1:0]   out_span_r, out_span_nxt;
  logic                        out_flat_r, out_flat_nxt;
  logic                        out_stats_r, out_stats_nxt;

  logic                        in_accept;
  logic                        out_take;
  logic signed [SUM_W-1:0]     h_s;
  logic signed [SUM_W-1:0]     low_s;
  logic signed [SUM_W-1:0]     v_s;
  logic signed [SUM_W-1:0]     diff_s;
  logic        [SUM_W-1:0]     diff_mag;
  logic signed [SUM_W-1:0]     span_diff;
  logic        [RANGE_W-1:0]   span16;
  logic signed [SUM_W-1:0]     q_s;

  unit_cmd_t                   ucmd;
  unit_stat_t                  ustat;
  logic        [NORM_W-1:0]    uopa;
  logic        [FRAC_W-1:0]    uquo;
  logic        [NORM_W-1:0]    uprod;

  mmhn_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ucmd),
    .opa   (uopa),
    .opb   (span_r),
    .stat  (ustat),
    .quo   (uquo),
    .prod  (uprod)
  );

  // Handshakes.
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  // Operands widened for the signed result arithmetic.
  assign h_s       = SUM_W'(in_height_in);
  assign low_s     = SUM_W'(lowest_r);
  assign v_s       = $signed(SUM_W'(in_norm_in));
  assign diff_s    = h_s - low_s;
  assign diff_mag  = diff_s[SUM_W-1] ? SUM_W'(-diff_s) : SUM_W'(diff_s);
  assign span_diff = SUM_W'(highest_r) - low_s;
  assign span16    = span_diff[RANGE_W-1:0];

  // Signed quotient before clamping; a quotient at or above one clamps.
  assign q_s = ustat.big ? SAT_HI : $signed(SUM_W'(uquo));

  // Sequencer and state updates.
  always_comb begin
    state_nxt     = state_r;
    lowest_nxt    = lowest_r;
    highest_nxt   = highest_r;
    span_nxt      = span_r;
    flat_nxt      = flat_r;
    norm_nxt      = norm_r;
    started_nxt   = started_r;
    min_range_nxt = min_range_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    neg_nxt       = neg_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_low_nxt   = out_low_r;
    out_span_nxt  = out_span_r;
    out_flat_nxt  = out_flat_r;
    out_stats_nxt = out_stats_r;
    ucmd.start    = 1'b0;
    ucmd.op       = op_r;
    uopa          = '0;

    if (cfg_valid && cfg_ready) begin
      min_range_nxt = cfg_min_range;
    end

    if (out_take) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_kind)
            KIND_MEASURE: begin
              if (!norm_r) begin
                if (!started_r) begin
                  lowest_nxt  = in_height_in;
                  highest_nxt = in_height_in;
                  started_nxt = 1'b1;
                end else begin
                  if (in_height_in < lowest_r) begin
                    lowest_nxt = in_height_in;
                  end
                  if (in_height_in > highest_r) begin
                    highest_nxt = in_height_in;
                  end
                end
                if (in_last) begin
                  state_nxt = S_STATS;
                end
              end
            end
            KIND_NORMALIZE: begin
              stat_nxt = 1'b0;
              if (!norm_r) begin
                res_nxt   = sat_result(h_s);
                state_nxt = S_EMIT;
              end else if (span_r == '0) begin
                res_nxt   = sat_result(diff_s);
                state_nxt = S_EMIT;
              end else begin
                ucmd.start = 1'b1;
                ucmd.op    = OP_DIV;
                uopa       = NORM_W'(diff_mag[SAMPLE_W-1:0]);
                op_nxt     = OP_DIV;
                neg_nxt    = diff_s[SUM_W-1];
                state_nxt  = S_BUSY;
              end
            end
            KIND_RECOVER: begin
              stat_nxt = 1'b0;
              if (!norm_r) begin
                res_nxt   = sat_result(v_s);
                state_nxt = S_EMIT;
              end else begin
                if (span_r == '0) begin
                  res_nxt   = sat_result(v_s + low_s);
                  state_nxt = S_EMIT;
                end else begin
                  ucmd.start = 1'b1;
                  ucmd.op    = OP_MUL;
                  uopa       = in_norm_in;
                  op_nxt     = OP_MUL;
                  state_nxt  = S_BUSY;
                end
                // The end of a recover pass drops the normalized mark.
                if (in_last) begin
                  norm_nxt = 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_STATS: begin
        // Close the measure pass: span, flat test and the stats result.
        flat_nxt    = (span16 <= min_range_r);
        span_nxt    = (span16 <= min_range_r) ? '0 : span16;
        norm_nxt    = 1'b1;
        started_nxt = 1'b0;
        res_nxt     = '0;
        stat_nxt    = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_BUSY: begin
        if (ustat.done) begin
          if (op_r == OP_DIV) begin
            res_nxt = sat_result(neg_r ? -q_s : q_s);
          end else begin
            res_nxt = sat_result(low_s + $signed(SUM_W'(uprod)));
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // Move the result into the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_low_nxt   = stat_r ? lowest_r : '0;
          out_span_nxt  = stat_r ? span_r : '0;
          out_flat_nxt  = stat_r && flat_r;
          out_stats_nxt = stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lowest_r    <= '0;
      highest_r   <= '0;
      span_r      <= '0;
      flat_r      <= 1'b0;
      norm_r      <= 1'b0;
      started_r   <= 1'b0;
      min_range_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lowest_r    <= lowest_nxt;
      highest_r   <= highest_nxt;
      span_r      <= span_nxt;
      flat_r      <= flat_nxt;
      norm_r      <= norm_nxt;
      started_r   <= started_nxt;
      min_range_r <= min_range_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r       <= res_nxt;
    stat_r      <= stat_nxt;
    neg_r       <= neg_nxt;
    op_r        <= op_nxt;
    out_res_r   <= out_res_nxt;
    out_low_r   <= out_low_nxt;
    out_span_r  <= out_span_nxt;
    out_flat_r  <= out_flat_nxt;
    out_stats_r <= out_stats_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_lowest_out   = out_low_r;
  assign out_span_out     = out_span_r;
  assign out_is_flat      = out_flat_r;
  assign out_stats_valid  = out_stats_r;

  // The shared unit finishes only while the sequencer waits for it.
  `MMHN_ASSERT_IMPL(a_done_in_busy, ustat.done, state_r == S_BUSY)
  // A last measure sample outside a normalized pass closes the pass next.
  `MMHN_ASSERT_NEXT(a_last_closes, in_accept && in_kind == KIND_MEASURE && in_last && !norm_r,
                    state_r == S_STATS)
  // A stats result carries a zero value, and a flat pass a zero span.
  `MMHN_ASSERT_IMPL(a_stats_zero, out_valid_r && out_stats_r,
                    out_res_r == '0 && (!out_flat_r || out_span_r == '0))
  // Mapping results carry no statistics.
  `MMHN_ASSERT_IMPL(a_map_no_stats, out_valid_r && !out_stats_r,
                    out_low_r == '0 && out_span_r == '0 && !out_flat_r)

endmodule

`default_nettype wire
